>>> rtl/core/sme_pkg.sv
`default_nettype none
package sme_pkg;

  typedef enum logic [3:0] {
    OP_PUSH_IMM = 4'd0,
    OP_PUSH_REG = 4'd1,
    OP_POP_REG  = 4'd2,
    OP_ADD      = 4'd3,
    OP_SUB      = 4'd4,
    OP_MUL      = 4'd5,
    OP_DIV      = 4'd6,
    OP_SQRT     = 4'd7,
    OP_SIN      = 4'd8,
    OP_COS      = 4'd9,
    OP_IN       = 4'd10,
    OP_OUT      = 4'd11,
    OP_HALT     = 4'd12,
    OP_NOP13    = 4'd13,
    OP_NOP14    = 4'd14,
    OP_NOP15    = 4'd15
  } op_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_UNDER = 3'd1,
    ST_OVER  = 3'd2,
    ST_DIVZ  = 3'd3,
    ST_NEGSQ = 3'd4,
    ST_HALT  = 3'd5
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic take;      // latch a new instruction
    logic rd_req;    // issue a stack read at sp-1
    logic pop1;      // capture first popped word (right operand)
    logic pop2;      // capture second popped word (left operand)
    logic start_it;  // start the iterative unit
    logic finish;    // commit result and raise output
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [3:0] op;
    logic       halted;
    logic       it_busy;
    logic       out_busy;
  } dp_stat_t;

endpackage
`default_nettype wire

>>> rtl/core/sme_ram.sv
`default_nettype none
module sme_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

>>> rtl/core/sme_ctrl.sv
`default_nettype none
module sme_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire sme_pkg::dp_stat_t stat_i,
  output sme_pkg::dp_cmd_t      cmd_o
);
  import sme_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RD1   = 7'b0000010,
    S_CAP1  = 7'b0000100,
    S_CAP2  = 7'b0001000,
    S_ITER  = 7'b0010000,
    S_WAIT  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  op_e    op;
  logic   two_pops, one_pop, needs_it;

  assign op = op_e'(stat_i.op);
  always_comb begin
    two_pops = (op == OP_ADD) || (op == OP_SUB) || (op == OP_MUL) || (op == OP_DIV);
    one_pop  = (op == OP_POP_REG) || (op == OP_SQRT) || (op == OP_SIN) ||
               (op == OP_COS) || (op == OP_OUT);
    needs_it = (op == OP_DIV) || (op == OP_SQRT);
  end

  assign in_stall_o = (state_q != S_IDLE) || stat_i.out_busy;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && !in_stall_o) begin
          cmd_o.take = 1'b1;
          state_d    = S_RD1;
        end
      end
      S_RD1: begin
        // read of top word issued here; halted, or ops that pop nothing, skip straight on
        if (stat_i.halted || !(two_pops || one_pop)) begin
          state_d = S_DONE;
        end else begin
          cmd_o.rd_req = 1'b1;
          state_d      = S_CAP1;
        end
      end
      S_CAP1: begin
        cmd_o.pop1 = 1'b1;
        if (two_pops) begin
          cmd_o.rd_req = 1'b1;
          state_d      = S_CAP2;
        end else if (needs_it) begin
          state_d = S_ITER;
        end else begin
          state_d = S_DONE;
        end
      end
      S_CAP2: begin
        cmd_o.pop2 = 1'b1;
        state_d    = needs_it ? S_ITER : S_DONE;
      end
      S_ITER: begin
        cmd_o.start_it = 1'b1;
        state_d        = S_WAIT;
      end
      S_WAIT: begin
        if (!stat_i.it_busy) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/sme_iter.sv
`default_nettype none
module sme_iter (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic        is_sqrt_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic             busy_o,
  output logic [31:0]      res_o
);
  // shared one-bit-per-cycle unit: restoring divide on magnitudes, or
  // digit-by-digit square root (two radicand bits per cycle)
  logic        busy_q, sqrt_q, neg_q;
  logic [5:0]  cnt_q;
  logic [31:0] num_q, den_q, quo_q, rem_q;
  logic [32:0] trial;
  logic [33:0] strial;
  logic [31:0] ma, mb;
  logic [33:0] srem;

  assign ma = a_i[31] ? (32'd0 - a_i) : a_i;
  assign mb = b_i[31] ? (32'd0 - b_i) : b_i;
  assign trial  = {rem_q, num_q[31]} - {1'b0, den_q};
  assign srem   = {rem_q, num_q[31:30]};
  assign strial = srem - {quo_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= is_sqrt_i ? 6'd16 : 6'd32;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sqrt_q <= is_sqrt_i;
      neg_q  <= a_i[31] ^ b_i[31];
      num_q  <= is_sqrt_i ? a_i : ma;
      den_q  <= mb;
      quo_q  <= '0;
      rem_q  <= '0;
    end else if (busy_q) begin
      if (sqrt_q) begin
        num_q <= {num_q[29:0], 2'b00};
        if (!strial[33]) begin
          rem_q <= strial[31:0];
          quo_q <= {quo_q[30:0], 1'b1};
        end else begin
          rem_q <= srem[31:0];
          quo_q <= {quo_q[30:0], 1'b0};
        end
      end else begin
        num_q <= {num_q[30:0], 1'b0};
        if (!trial[32]) begin
          rem_q <= trial[31:0];
          quo_q <= {quo_q[30:0], 1'b1};
        end else begin
          rem_q <= {rem_q[30:0], num_q[31]};
          quo_q <= {quo_q[30:0], 1'b0};
        end
      end
    end
  end

  assign busy_o = busy_q;
  assign res_o  = (!sqrt_q && neg_q) ? (32'd0 - quo_q) : quo_q;
endmodule
`default_nettype wire

>>> rtl/core/sme_dp.sv
`default_nettype none
module sme_dp #(
  parameter int unsigned StackDepth = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sme_pkg::dp_cmd_t  cmd_i,
  output sme_pkg::dp_stat_t      stat_o,
  input  wire logic [3:0]        operation_i,
  input  wire logic signed [31:0] operand_value_i,
  input  wire logic [1:0]        register_index_i,
  output logic                   out_valid_o,
  output logic signed [31:0]     out_value_o,
  output logic [2:0]             status_o,
  output logic                   res_valid_o,
  input  wire logic              res_stall_i
);
  import sme_pkg::*;

  localparam int unsigned AddrW = $clog2(StackDepth);
  localparam int unsigned SpW   = $clog2(StackDepth + 1);
  localparam logic [SpW-1:0] SpFull = SpW'(StackDepth);

  logic [SpW-1:0]  sp_q, rd_sp_q;
  logic [31:0]     gr_q [4];
  logic            halted_q;
  op_e             op_q;
  logic [31:0]     imm_q;
  logic [1:0]      ri_q;
  logic [31:0]     b_q, a_q;
  status_e         st_q;
  logic [31:0]     rdata;
  logic [AddrW-1:0] raddr;
  logic            we;
  logic [AddrW-1:0] waddr;
  logic [31:0]     wdata;
  logic            it_busy;
  logic [31:0]     it_res;
  logic            rv_q, ov_q;
  logic [31:0]     oval_q;
  logic [2:0]      ost_q;
  logic            push;
  logic [31:0]     pval;
  status_e         fst;
  logic [63:0]     prod;

  // reads track the pointer as pops take place
  assign raddr = AddrW'(rd_sp_q - SpW'(1));

  sme_ram #(.Width(32), .Depth(StackDepth)) u_stack (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  sme_iter u_iter (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.start_it),
    .is_sqrt_i(op_q == OP_SQRT),
    .a_i      (op_q == OP_SQRT ? b_q : a_q),
    .b_i      (b_q),
    .busy_o   (it_busy),
    .res_o    (it_res)
  );

  assign prod = 64'(a_q) * 64'(b_q);

  always_comb begin
    push = 1'b0;
    pval = '0;
    fst  = st_q;
    unique case (op_q)
      OP_PUSH_IMM, OP_IN: begin push = 1'b1; pval = imm_q; end
      OP_PUSH_REG: begin push = 1'b1; pval = gr_q[ri_q]; end
      OP_ADD: begin push = 1'b1; pval = a_q + b_q; end
      OP_SUB: begin push = 1'b1; pval = a_q - b_q; end
      OP_MUL: begin push = 1'b1; pval = prod[31:0]; end
      OP_DIV: begin
        push = 1'b1;
        if (b_q == 32'd0) begin
          pval = '0;
          if (fst == ST_OK) fst = ST_DIVZ;
        end else begin
          pval = it_res;
        end
      end
      OP_SQRT: begin
        push = 1'b1;
        if (b_q[31]) begin
          pval = '0;
          if (fst == ST_OK) fst = ST_NEGSQ;
        end else begin
          pval = it_res;
        end
      end
      OP_SIN: begin push = 1'b1; pval = '0; end
      OP_COS: begin push = 1'b1; pval = (b_q == 32'd0) ? 32'd1 : 32'd0; end
      default: ;
    endcase
    if (halted_q) begin
      push = 1'b0;
      fst  = ST_HALT;
    end else if (op_q == OP_HALT) begin
      fst = ST_HALT;
    end
    if (push && sp_q >= SpFull && fst == ST_OK) begin
      fst = ST_OVER;
    end
  end

  assign we    = cmd_i.finish && push && (sp_q < SpFull);
  assign waddr = AddrW'(sp_q);
  assign wdata = pval;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q     <= '0;
      rd_sp_q  <= '0;
      halted_q <= 1'b0;
      for (int i = 0; i < 4; i++) gr_q[i] <= '0;
      rv_q     <= 1'b0;
    end else begin
      if (rv_q && !res_stall_i) rv_q <= 1'b0;
      if (cmd_i.rd_req && rd_sp_q != '0) begin
        rd_sp_q <= rd_sp_q - SpW'(1);
      end
      if (cmd_i.pop1 || cmd_i.pop2) begin
        sp_q <= rd_sp_q;
      end
      if (cmd_i.finish) begin
        rv_q <= 1'b1;
        if (we) begin
          sp_q    <= sp_q + SpW'(1);
          rd_sp_q <= sp_q + SpW'(1);
        end else begin
          rd_sp_q <= sp_q;
        end
        if (!halted_q && op_q == OP_HALT) halted_q <= 1'b1;
        if (!halted_q && op_q == OP_POP_REG) gr_q[ri_q] <= b_q;
      end
    end
  end

  // popped word is zero on underflow; first fault wins
  logic pop_ok;
  assign pop_ok = (sp_q != rd_sp_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      op_q  <= op_e'(operation_i);
      imm_q <= operand_value_i;
      ri_q  <= register_index_i;
      b_q   <= '0;
      a_q   <= '0;
      st_q  <= ST_OK;
    end
    if (cmd_i.pop1) begin
      b_q <= pop_ok ? rdata : 32'd0;
      if (!pop_ok) st_q <= ST_UNDER;
    end
    if (cmd_i.pop2) begin
      a_q <= pop_ok ? rdata : 32'd0;
      if (!pop_ok && st_q == ST_OK) st_q <= ST_UNDER;
    end
    if (cmd_i.finish) begin
      ost_q  <= fst;
      ov_q   <= !halted_q && op_q == OP_OUT && st_q == ST_OK;
      oval_q <= (!halted_q && op_q == OP_OUT && st_q == ST_OK) ? b_q : 32'd0;
    end
  end

  assign out_valid_o = ov_q;
  assign out_value_o = oval_q;
  assign status_o    = ost_q;
  assign res_valid_o = rv_q;

  assign stat_o.op       = op_q;
  assign stat_o.halted   = halted_q;
  assign stat_o.it_busy  = it_busy;
  // a waiting word blocks new work only when it is still held
  assign stat_o.out_busy = rv_q && res_stall_i;
endmodule
`default_nettype wire

>>> rtl/core/stack_machine_execute_top.sv
// each instruction steps through the controller states in order: take in idle,
// rd1, cap1 for pops, cap2 for binary ops, iter and wait for sqrt and div (one
// shared iterative unit) and done, which commits the result
// one instruction at a time; sqrt and div hold the input for their iterations
// a word held on a stalled output blocks the next instruction until it leaves
// reset: asynchronous, clears pointer, registers, halt flag; stack ram not cleared
`default_nettype none
module stack_machine_execute_top #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [3:0]         operation_i,
  input  wire logic signed [31:0] operand_value_i,
  input  wire logic [1:0]         register_index_i,
  output logic                    res_valid_o,
  input  wire logic               res_stall_i,
  output logic                    out_valid_o,
  output logic signed [31:0]      out_value_o,
  output logic [2:0]              status_o
);
  import sme_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sme_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  sme_dp #(.StackDepth(STACK_DEPTH)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .operation_i     (operation_i),
    .operand_value_i (operand_value_i),
    .register_index_i(register_index_i),
    .out_valid_o     (out_valid_o),
    .out_value_o     (out_value_o),
    .status_o        (status_o),
    .res_valid_o     (res_valid_o),
    .res_stall_i     (res_stall_i)
  );

  a_one_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start_it |=> stat.it_busy) else $error("iterative unit did not start");
  a_finish_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> res_valid_o) else $error("finished word not shown");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.take |-> !(res_valid_o && res_stall_i)) else $error("took while blocked");
endmodule
`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 1ps
module tb;
  import sme_pkg::*;

  localparam int unsigned Depth = 64;
  localparam int unsigned Limit = 2000000;

  typedef struct packed {
    logic        has_word;
    logic [31:0] word;
    status_e     st;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [3:0] operation_i = '0;
  logic signed [31:0] operand_value_i = '0;
  logic [1:0] register_index_i = '0;
  logic res_valid_o;
  logic res_stall_i = 1'b0;
  logic out_valid_o;
  logic signed [31:0] out_value_o;
  logic [2:0] status_o;

  stack_machine_execute_top #(.STACK_DEPTH(Depth)) dut (.*);

  initial forever #1 clk_i = ~clk_i;

  // machine state as the block should hold it
  logic [31:0] stk_mem [Depth];
  int unsigned sp;
  logic [31:0] gpr [4];
  logic halted;
  status_e cur_st;
  outcome_t pending_q [$];

  int unsigned fails = 0;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_cycles = 0;

  function automatic void flag(status_e s);
    if (cur_st == ST_OK) cur_st = s;
  endfunction

  function automatic void push_w(logic [31:0] v);
    if (sp >= Depth) begin
      flag(ST_OVER);
      return;
    end
    stk_mem[sp] = v;
    sp++;
  endfunction

  function automatic logic [31:0] pop_w(output logic ok);
    if (sp == 0) begin
      flag(ST_UNDER);
      ok = 1'b0;
      return '0;
    end
    sp--;
    ok = 1'b1;
    return stk_mem[sp];
  endfunction

  function automatic logic [31:0] isqrt(logic [31:0] x);
    logic [31:0] r;
    r = 0;
    for (int k = 15; k >= 0; k--) begin
      logic [31:0] t;
      t = r | (32'd1 << k);
      if (64'(t) * 64'(t) <= 64'(x)) r = t;
    end
    return r;
  endfunction

  function automatic logic [31:0] div_trunc(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  function automatic outcome_t execute(op_e op, logic [31:0] imm, logic [1:0] ri);
    outcome_t o;
    logic ok;
    logic [31:0] a, b, r;
    o = '0;
    cur_st = ST_OK;
    if (halted) begin
      cur_st = ST_HALT;
    end else begin
      case (op)
        OP_PUSH_IMM, OP_IN: push_w(imm);
        OP_PUSH_REG: push_w(gpr[ri]);
        OP_POP_REG: gpr[ri] = pop_w(ok);
        OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
          b = pop_w(ok);
          a = pop_w(ok);
          case (op)
            OP_ADD: r = a + b;
            OP_SUB: r = a - b;
            OP_MUL: r = a * b;
            default: begin
              if (b == 0) begin
                flag(ST_DIVZ);
                r = 0;
              end else begin
                r = div_trunc(a, b);
              end
            end
          endcase
          push_w(r);
        end
        OP_SQRT: begin
          a = pop_w(ok);
          if (a[31]) begin
            flag(ST_NEGSQ);
            push_w(0);
          end else begin
            push_w(isqrt(a));
          end
        end
        OP_SIN: begin
          a = pop_w(ok);
          push_w(0);
        end
        OP_COS: begin
          a = pop_w(ok);
          push_w(a == 0 ? 32'd1 : 32'd0);
        end
        OP_OUT: begin
          a = pop_w(ok);
          if (ok) begin
            o.has_word = 1'b1;
            o.word = a;
          end
        end
        OP_HALT: begin
          halted = 1'b1;
          cur_st = ST_HALT;
        end
        default: ;
      endcase
    end
    o.st = cur_st;
    return o;
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > Limit) begin
      $display("timeout at %0t", $time);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver stall
  always @(posedge clk_i) begin
    if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      res_stall_i <= 1'b1;
    end else begin
      res_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    outcome_t e;
    if (rst_ni && res_valid_o && !res_stall_i) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected word out=%0b val=%0d st=%0d", $time, out_valid_o,
                 out_value_o, status_o);
        fails++;
      end else begin
        e = pending_q.pop_front();
        if (out_valid_o !== e.has_word) begin
          $display("%0t: out_valid exp %0b got %0b", $time, e.has_word, out_valid_o);
          fails++;
        end
        if (out_value_o !== e.word) begin
          $display("%0t: out_value exp %0d got %0d", $time, $signed(e.word), out_value_o);
          fails++;
        end
        if (status_o !== e.st) begin
          $display("%0t: status exp %0d got %0d", $time, e.st, status_o);
          fails++;
        end
      end
    end
  end

  // valid stays up between back-to-back words and drops only while idling
  task automatic send_word(op_e op, logic [31:0] imm, logic [1:0] ri);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    operand_value_i <= imm;
    register_index_i <= ri;
    do @(posedge clk_i); while (in_stall_o);
    pending_q.push_back(execute(op, imm, ri));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rnd_val();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'(int'($urandom_range(20)) - 10);
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    send_word(OP_POP_REG, 0, 2'd3);
    send_word(OP_OUT, 0, 0);
    send_word(OP_ADD, 0, 0);
    send_word(OP_PUSH_IMM, 32'h8000_0000, 0);
    send_word(OP_PUSH_IMM, 32'hffff_ffff, 0);
    send_word(OP_DIV, 0, 0);
    send_word(OP_PUSH_IMM, 0, 0);
    send_word(OP_DIV, 0, 0);
    send_word(OP_PUSH_IMM, 32'h7fff_ffff, 0);
    send_word(OP_SQRT, 0, 0);
    send_word(OP_PUSH_IMM, 32'hffff_fff0, 0);
    send_word(OP_SQRT, 0, 0);
    send_word(OP_SIN, 0, 0);
    send_word(OP_COS, 0, 0);
    send_word(OP_COS, 0, 0);
    send_word(OP_IN, 32'd7, 0);
    send_word(OP_PUSH_IMM, -32'sd3, 0);
    send_word(OP_MUL, 0, 0);
    send_word(OP_SUB, 0, 0);
    send_word(OP_POP_REG, 0, 2'd1);
    send_word(OP_PUSH_REG, 0, 2'd1);
    send_word(OP_OUT, 0, 0);
    send_word(op_e'(4'd13), 0, 0);
    send_word(OP_NOP15, 0, 0);
    drain();
  endtask

  task automatic test_overflow();
    for (int k = 0; k < Depth + 3; k++) send_word(OP_PUSH_IMM, $urandom, 2'($urandom));
    send_word(OP_ADD, 0, 0);
    send_word(OP_PUSH_IMM, 0, 0);
    send_word(OP_PUSH_IMM, 1, 0);
    for (int k = 0; k < Depth + 2; k++) send_word(OP_OUT, 0, 0);
    drain();
  endtask

  // mostly well-formed programs, a shallow stack and occasional noise
  task automatic test_random(int unsigned n, int unsigned idle, int unsigned stall);
    op_e op;
    send_idle_pct = idle;
    stall_pct = stall;
    for (int unsigned k = 0; k < n; k++) begin
      if ($urandom_range(9) == 0) op = op_e'($urandom_range(15));
      else if (sp < 2) op = ($urandom_range(1) != 0) ? OP_PUSH_IMM : OP_PUSH_REG;
      else if (sp > 10) op = op_e'($urandom_range(11) | 4'd2);
      else op = op_e'($urandom_range(11));
      if (op == OP_HALT && $urandom_range(3) != 0) op = OP_OUT;
      if (op == OP_HALT) op = OP_IN;
      send_word(op, rnd_val(), 2'($urandom));
    end
    drain();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 300;
    for (int k = 0; k < 30; k++) send_word(op_e'($urandom_range(11)), rnd_val(), 2'($urandom));
    drain();
  endtask

  task automatic test_halt();
    send_idle_pct = 20;
    stall_pct = 20;
    send_word(OP_PUSH_IMM, 5, 0);
    send_word(OP_HALT, 0, 0);
    for (int k = 0; k < 20; k++) send_word(op_e'($urandom_range(15)), rnd_val(), 2'($urandom));
    drain();
  endtask

  initial begin
    sp = 0;
    halted = 1'b0;
    foreach (gpr[k]) gpr[k] = '0;
    foreach (stk_mem[k]) stk_mem[k] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_overflow();
    test_random(260, 0, 0);
    test_random(260, 54, 0);
    test_backpressure();
    test_random(260, 0, 54);
    test_random(260, 29, 29);
    test_halt();
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
